/* sv/ntl_pkg.sv */
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared types, codes and the microcode program of the thermistor table
// lookup: control word layout, register indexes and stream field offsets.
// ----------------------------------------------------------------------------
package ntl_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_INDEX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CODE  = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_FAULT_LIMIT  = 8'd30;
    localparam logic [7:0] RST_UPPER_INDEX  = 8'd190;
    localparam logic [7:0] RST_RECOVER_LOW  = 8'd10;
    localparam logic [7:0] RST_RECOVER_HIGH = 8'd90;
    localparam logic [7:0] RST_DEFAULT_CODE = 8'd60;

    // Request kinds carried in the input tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Input tdata field offsets
    localparam int IN_INDEX_LSB  = 0;
    localparam int IN_VALUE_LSB  = 8;
    localparam int IN_SAMPLE_LSB = 24;
    localparam int IN_HOLD_BIT   = 40;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 16;

    // Microcode step addresses
    typedef logic [2:0] step_t;
    localparam step_t ST_IDLE = 3'd0;
    localparam step_t ST_RD0  = 3'd1;
    localparam step_t ST_CHK0 = 3'd2;
    localparam step_t ST_CHKU = 3'd3;
    localparam step_t ST_SRCH = 3'd4;
    localparam step_t ST_UPD  = 3'd5;

    // Datapath operation of a step
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_NONE,
        OP_CHK0,
        OP_CHKU,
        OP_SRCH,
        OP_UPD
    } op_t;

    // Table read address source
    typedef enum logic [1:0] {
        RA_ZERO,
        RA_UPPER,
        RA_PROBE
    } raddr_sel_t;

    // Branch condition
    typedef enum logic [2:0] {
        CC_ALWAYS,
        CC_START,
        CC_OOR,
        CC_LAST,
        CC_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t        op;
        raddr_sel_t raddr;
        cond_t      cond;
        step_t      jump_true;
        step_t      jump_false;
    } ucode_t;

    // Status flags fed back from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic oor;
        logic last;
        logic out_free;
    } seq_flags_t;

    // Control store
    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        unique case (addr)
            ST_IDLE: w = '{OP_WAIT, RA_ZERO,  CC_START,    ST_RD0,  ST_IDLE};
            ST_RD0:  w = '{OP_NONE, RA_ZERO,  CC_ALWAYS,   ST_CHK0, ST_CHK0};
            ST_CHK0: w = '{OP_CHK0, RA_UPPER, CC_ALWAYS,   ST_CHKU, ST_CHKU};
            ST_CHKU: w = '{OP_CHKU, RA_PROBE, CC_OOR,      ST_UPD,  ST_SRCH};
            ST_SRCH: w = '{OP_SRCH, RA_PROBE, CC_LAST,     ST_UPD,  ST_SRCH};
            ST_UPD:  w = '{OP_UPD,  RA_ZERO,  CC_OUT_FREE, ST_IDLE, ST_UPD};
            default: w = '{OP_NONE, RA_ZERO,  CC_ALWAYS,   ST_IDLE, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/ntl_sequencer.sv */
// ----------------------------------------------------------------------------
// ntl_sequencer
// Step counter over the control store: fetches one control word per step
// and branches on the datapath flags.
// ----------------------------------------------------------------------------
module ntl_sequencer
    import ntl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ucode_t     ctrl,
    output step_t      step
);

    step_t step_reg;
    step_t step_next;
    logic  taken;

    // Fetch the current control word
    assign ctrl = ucode_rom(step_reg);
    assign step = step_reg;

    // Evaluate the branch condition
    always_comb
    begin
        unique case (ctrl.cond)
            CC_ALWAYS:   taken = 1'b1;
            CC_START:    taken = flags.start;
            CC_OOR:      taken = flags.oor;
            CC_LAST:     taken = flags.last;
            CC_OUT_FREE: taken = flags.out_free;
            default:     taken = 1'b1;
        endcase
        step_next = taken ? ctrl.jump_true : ctrl.jump_false;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* sv/ntc_table_temperature_lookup.sv */
// ----------------------------------------------------------------------------
// ntc_table_temperature_lookup
// Thermistor temperature lookup: voltage table, range check with fault
// debounce, binary search for the temperature code, fault recovery.
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one table entry. A sample request (tuser 1)
// with hold set is dropped. Any other sample is checked against table entry 0
// and the upper-valid entry, then searched one probe per cycle over the single
// read port of the table; an out-of-range reading skips the search. The block
// stays busy until the update step has placed the result, which waits for a
// free output register. One result per processed sample goes to the output
// register, so the next request is accepted while it waits. The table has no
// reset; every entry the search may touch must be loaded first.
module ntc_table_temperature_lookup
    import ntl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tdata: table_index[7:0], table_value[23:8], sample[39:24], hold[40]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: req_type[0]
    input  logic [0:0]            s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: temp_code[7:0], sensor_fault[8]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] HALF     = AW'(TABLE_DEPTH / 2);
    localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(TABLE_DEPTH);

    // Configuration registers
    logic [7:0] fault_limit_reg;
    logic [7:0] upper_index_reg;
    logic [7:0] recover_low_reg;
    logic [7:0] recover_high_reg;
    logic [7:0] default_code_reg;

    // Block state
    logic [7:0] debounce_reg;
    logic       fault_reg;
    logic [7:0] code_reg;

    // Datapath registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic                   oor_reg;
    logic [AW-1:0]          pos_reg;
    logic [AW-1:0]          step_reg;
    logic [AW:0]            probe_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_code_reg;
    logic       out_fault_reg;

    // Table storage
    logic [SAMPLE_BITS-1:0] volt_mem [TABLE_DEPTH];

    ucode_t     ctrl;
    step_t      seq_step;
    seq_flags_t flags;

    logic                   in_accept;
    logic                   is_sample;
    logic                   start;
    logic                   load_en;
    logic [CW-1:0]          upper_ext;
    logic [AW-1:0]          upper_addr;
    logic [AW-1:0]          raddr;
    logic                   oor_now;
    logic                   probe_ok;
    logic                   hit;
    logic [AW-1:0]          pos_new;
    logic [AW-1:0]          step_new;
    logic [AW:0]            probe_next;
    logic [7:0]             found_code;
    logic                   in_window;
    logic                   out_free;

    ntl_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .step  (seq_step)
    );

    // Decode the incoming request
    assign s_tready  = (ctrl.op == OP_WAIT);
    assign in_accept = s_tvalid & s_tready;
    assign is_sample = (s_tuser[0] == REQ_SAMPLE);
    assign start     = in_accept & is_sample & ~s_tdata[IN_HOLD_BIT];
    assign load_en   = in_accept & ~is_sample &
                       (CW'(s_tdata[IN_INDEX_LSB +: 8]) <= LAST_IDX);

    // Saturate the upper-valid index to the table
    assign upper_ext  = CW'(upper_index_reg);
    assign upper_addr = (upper_ext >= LAST_IDX) ? AW'(LAST_IDX) : AW'(upper_ext);

    // Search step: judge the probe just read and form the next one
    assign probe_ok   = (probe_reg < DEPTH_EXT);
    assign hit        = probe_ok && (sample_reg >= rdata_reg);
    assign pos_new    = hit ? probe_reg[AW-1:0] : pos_reg;
    assign step_new   = step_reg >> 1;
    assign probe_next = (ctrl.op == OP_CHKU) ? {1'b0, HALF}
                                             : ({1'b0, pos_new} + {1'b0, step_new});

    assign oor_now    = oor_reg | (sample_reg > rdata_reg);
    assign found_code = 8'(pos_reg);
    assign in_window  = (found_code >= recover_low_reg) && (found_code <= recover_high_reg);
    assign out_free   = ~out_valid_reg | m_tready;

    // Select the table read address
    always_comb
    begin
        unique case (ctrl.raddr)
            RA_ZERO:  raddr = '0;
            RA_UPPER: raddr = upper_addr;
            RA_PROBE: raddr = probe_next[AW-1:0];
            default:  raddr = '0;
        endcase
    end

    assign flags = '{start:    start,
                     oor:      oor_now,
                     last:     (step_reg == AW'(1)),
                     out_free: out_free};

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            volt_mem[AW'(s_tdata[IN_INDEX_LSB +: 8])] <= s_tdata[IN_VALUE_LSB +: SAMPLE_BITS];
        end
        rdata_reg <= volt_mem[raddr];
    end

    // Search datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= s_tdata[IN_SAMPLE_LSB +: SAMPLE_BITS];
        end
        case (ctrl.op)
            OP_CHK0:
            begin
                oor_reg <= (sample_reg < rdata_reg);
            end
            OP_CHKU:
            begin
                oor_reg   <= oor_now;
                pos_reg   <= '0;
                step_reg  <= HALF;
                probe_reg <= probe_next;
            end
            OP_SRCH:
            begin
                pos_reg   <= pos_new;
                step_reg  <= step_new;
                probe_reg <= probe_next;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_limit_reg  <= RST_FAULT_LIMIT;
            upper_index_reg  <= RST_UPPER_INDEX;
            recover_low_reg  <= RST_RECOVER_LOW;
            recover_high_reg <= RST_RECOVER_HIGH;
            default_code_reg <= RST_DEFAULT_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAULT_LIMIT:  fault_limit_reg  <= cfg_wdata;
                CFG_UPPER_INDEX:  upper_index_reg  <= cfg_wdata;
                CFG_RECOVER_LOW:  recover_low_reg  <= cfg_wdata;
                CFG_RECOVER_HIGH: recover_high_reg <= cfg_wdata;
                CFG_DEFAULT_CODE: default_code_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Fault debounce, code update and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= '0;
            fault_reg     <= 1'b0;
            code_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_code_reg  <= '0;
            out_fault_reg <= 1'b0;
        end
        else
        begin
            if ((ctrl.op == OP_UPD) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (oor_reg)
                begin
                    if (debounce_reg < fault_limit_reg)
                    begin
                        debounce_reg  <= debounce_reg + 8'd1;
                        out_fault_reg <= fault_reg;
                        out_code_reg  <= code_reg;
                    end
                    else
                    begin
                        fault_reg     <= 1'b1;
                        code_reg      <= default_code_reg;
                        out_fault_reg <= 1'b1;
                        out_code_reg  <= default_code_reg;
                    end
                end
                else if (fault_reg)
                begin
                    out_code_reg  <= code_reg;
                    out_fault_reg <= 1'b1;
                    if (in_window)
                    begin
                        if (debounce_reg != 8'd0)
                        begin
                            debounce_reg <= debounce_reg - 8'd1;
                        end
                        else
                        begin
                            fault_reg     <= 1'b0;
                            out_fault_reg <= 1'b0;
                        end
                    end
                end
                else
                begin
                    debounce_reg  <= '0;
                    code_reg      <= found_code;
                    out_code_reg  <= found_code;
                    out_fault_reg <= 1'b0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_fault_reg, out_code_reg};

    // A new result only comes out of the update step
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == OP_UPD))
        else $error("result appeared outside the update step");

    // The fault is only raised by an out-of-range reading
    a_fault_needs_oor: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fault_reg) |-> $past(oor_reg) && $past(debounce_reg >= fault_limit_reg))
        else $error("fault raised without an out-of-range reading at the limit");

    // The probe stride never runs out inside the search loop
    a_search_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_step == ST_SRCH) |-> (step_reg != '0))
        else $error("search step entered with zero stride");

    // The request side is closed while a sample is in work
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("request accepted while a sample is in work");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermistor table lookup. Loads an ascending
// voltage table, runs directed and random sample requests through several
// register settings and idle patterns, predicts each temperature code and
// fault flag, and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import ntl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH     = 256;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic        req_type;
        logic [7:0]  table_index;
        logic [15:0] table_value;
        logic [15:0] sample;
        logic        hold;
    } lookup_req_t;

    typedef struct {
        logic [7:0] temp_code;
        logic       sensor_fault;
    } temp_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [7:0]            cfg_wdata = '0;

    // Request stream, predicted results, failure count
    lookup_req_t  pending_reqs[$];
    temp_result_t expected_temps[$];
    lookup_req_t  drv_cur;
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           drv_gap_pct   = 0;
    int           rcv_stall_pct = 0;

    // Predictor state and register copies
    logic [15:0] temp_tbl [TBL_DEPTH];
    logic [7:0]  debounce_cnt     = '0;
    logic        fault_active     = 1'b0;
    logic [7:0]  code_now         = '0;
    logic [7:0]  cfg_fault_limit  = RST_FAULT_LIMIT;
    logic [7:0]  cfg_upper_index  = RST_UPPER_INDEX;
    logic [7:0]  cfg_recover_low  = RST_RECOVER_LOW;
    logic [7:0]  cfg_recover_high = RST_RECOVER_HIGH;
    logic [7:0]  cfg_default_code = RST_DEFAULT_CODE;

    // Table contents as the stimulus generator sees them
    logic [15:0] gen_tbl [TBL_DEPTH];

    ntc_table_temperature_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the predicted sensor state for one accepted request; return 1 when
    // the request yields a temperature result.
    function automatic bit compute_temperature(input lookup_req_t r, output temp_result_t res);
        int         pos;
        int         stride;
        int         probe;
        logic [7:0] found;
        res.temp_code    = '0;
        res.sensor_fault = 1'b0;
        if (r.req_type == REQ_LOAD)
        begin
            temp_tbl[r.table_index] = r.table_value;
            return 1'b0;
        end
        if (r.hold)
            return 1'b0;
        if (r.sample < temp_tbl[0] || r.sample > temp_tbl[cfg_upper_index])
        begin
            // Out of range: debounce, then force the default code
            if (debounce_cnt < cfg_fault_limit)
                debounce_cnt = debounce_cnt + 8'd1;
            else
            begin
                fault_active = 1'b1;
                code_now     = cfg_default_code;
            end
        end
        else
        begin
            // Binary search for the last entry not above the sample
            pos    = 0;
            stride = TBL_DEPTH / 2;
            while (stride != 0)
            begin
                probe = pos + stride;
                if (probe < TBL_DEPTH && r.sample >= temp_tbl[probe[7:0]])
                    pos = probe;
                stride = stride >> 1;
            end
            found = pos[7:0];
            if (fault_active)
            begin
                if (found >= cfg_recover_low && found <= cfg_recover_high)
                begin
                    if (debounce_cnt != 8'd0)
                        debounce_cnt = debounce_cnt - 8'd1;
                    else
                        fault_active = 1'b0;
                end
            end
            else
            begin
                debounce_cnt = '0;
                code_now     = found;
            end
        end
        res.temp_code    = code_now;
        res.sensor_fault = fault_active;
        return 1'b1;
    endfunction

    // Queue one request; track table loads for later sample picking
    function automatic void push_req(input logic req, input int idx, input int val,
                                     input int smp, input bit hold);
        lookup_req_t r;
        r.req_type    = req;
        r.table_index = idx[7:0];
        r.table_value = val[15:0];
        r.sample      = smp[15:0];
        r.hold        = hold;
        if (req == REQ_LOAD)
            gen_tbl[idx[7:0]] = val[15:0];
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_load(input int idx, input int val);
        push_req(REQ_LOAD, idx, val, $urandom_range(65535, 0), 1'($urandom_range(1, 0)));
    endfunction

    function automatic void push_sample(input int smp, input bit hold);
        push_req(REQ_SAMPLE, $urandom_range(255, 0), $urandom_range(65535, 0), smp, hold);
    endfunction

    // Load a fresh ascending table into every entry
    function automatic void build_table();
        int v;
        v = $urandom_range(3000, 64);
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            push_load(i, v);
            v = v + $urandom_range(200, 0);
        end
    endfunction

    function automatic int pick_below();
        if (gen_tbl[0] == 16'd0)
            return 0;
        return $urandom_range(gen_tbl[0] - 1, 0);
    endfunction

    function automatic int pick_above();
        int hi;
        hi = gen_tbl[cfg_upper_index];
        if (hi >= 65535)
            return 65535;
        return $urandom_range(65535, hi + 1);
    endfunction

    function automatic int pick_in_range();
        int lo;
        int hi;
        lo = gen_tbl[0];
        hi = gen_tbl[cfg_upper_index];
        if (lo > hi)
            return lo;
        return $urandom_range(hi, lo);
    endfunction

    // Sample that lands on a code inside the recovery window, if any exists
    function automatic int pick_in_window();
        int lo;
        int hi;
        lo = cfg_recover_low;
        hi = (cfg_recover_high > cfg_upper_index) ? cfg_upper_index : cfg_recover_high;
        if (lo > hi)
            return pick_in_range();
        return gen_tbl[8'($urandom_range(hi, lo))];
    endfunction

    // Random traffic: fault bursts, recovery bursts, in-range readings, held noise samples, table rewrites
    function automatic void gen_random(input int n_samples);
        int done;
        int kind;
        int len;
        int cap;
        int idx;
        int lo;
        int hi;
        done = 0;
        cap  = (cfg_fault_limit + 3 > 40) ? 40 : cfg_fault_limit + 3;
        while (done < n_samples)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 30)
            begin
                len = $urandom_range(cap, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_sample($urandom_range(1, 0) ? pick_below() : pick_above(), 1'b0);
                    done++;
                end
            end
            else if (kind < 55)
            begin
                len = $urandom_range(cap, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_sample(pick_in_window(), 1'b0);
                    done++;
                end
            end
            else if (kind < 85)
            begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                begin
                    push_sample(pick_in_range(), 1'b0);
                    done++;
                end
            end
            else if (kind < 93)
                push_sample($urandom_range(65535, 0), 1'b1);
            else
            begin
                // Rewrite one entry, mostly keeping the table in order
                idx = $urandom_range(255, 0);
                lo  = (idx > 0) ? gen_tbl[8'(idx - 1)] : 0;
                hi  = (idx < TBL_DEPTH - 1) ? gen_tbl[8'(idx + 1)] : 65535;
                if ($urandom_range(99, 0) < 80 && lo <= hi)
                    push_load(idx, $urandom_range(hi, lo));
                else
                    push_load(idx, $urandom_range(65535, 0));
            end
        end
    endfunction

    // Hold until all requests are taken and all results are back
    task automatic drain_all();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_temps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FAULT_LIMIT:  cfg_fault_limit  = val;
            CFG_UPPER_INDEX:  cfg_upper_index  = val;
            CFG_RECOVER_LOW:  cfg_recover_low  = val;
            CFG_RECOVER_HIGH: cfg_recover_high = val;
            CFG_DEFAULT_CODE: cfg_default_code = val;
            default: ;
        endcase
    endtask

    // Drain, program all registers, then set the idle pattern
    task automatic configure_phase(input logic [7:0] limit, input logic [7:0] upper,
                                   input logic [7:0] rlow, input logic [7:0] rhigh,
                                   input logic [7:0] dflt, input int gap_pct,
                                   input int stall_pct);
        drain_all();
        write_reg(CFG_FAULT_LIMIT, limit);
        write_reg(CFG_UPPER_INDEX, upper);
        write_reg(CFG_RECOVER_LOW, rlow);
        write_reg(CFG_RECOVER_HIGH, rhigh);
        write_reg(CFG_DEFAULT_CODE, dflt);
        @(posedge clk);
        cfg_we        <= 1'b0;
        drv_gap_pct   = gap_pct;
        rcv_stall_pct = stall_pct;
    endtask

    // Request driver: present queued requests, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        temp_result_t res;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (compute_temperature(drv_cur, res))
                    expected_temps.push_back(res);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= drv_gap_pct)
                begin
                    drv_cur  = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    // hold, sample, table_value, table_index from the top down
                    s_tdata  <= {7'b0, drv_cur.hold, drv_cur.sample,
                                 drv_cur.table_value, drv_cur.table_index};
                    s_tuser  <= drv_cur.req_type;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: stall at random, compare against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        temp_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_temps.size() == 0)
                begin
                    $error("unexpected result: temp_code %0d sensor_fault %0d",
                           m_tdata[7:0], m_tdata[8]);
                    error_count++;
                end
                else
                begin
                    want = expected_temps.pop_front();
                    if (m_tdata[7:0] !== want.temp_code)
                    begin
                        $error("temp_code mismatch: expected %0d, actual %0d",
                               want.temp_code, m_tdata[7:0]);
                        error_count++;
                    end
                    if (m_tdata[8] !== want.sensor_fault)
                    begin
                        $error("sensor_fault mismatch: expected %0d, actual %0d",
                               want.sensor_fault, m_tdata[8]);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99, 0) >= rcv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int saved;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, directed corners first
        configure_phase(RST_FAULT_LIMIT, RST_UPPER_INDEX, RST_RECOVER_LOW,
                        RST_RECOVER_HIGH, RST_DEFAULT_CODE, 0, 0);
        build_table();
        saved = gen_tbl[0];
        push_sample(gen_tbl[0] - 1, 1'b0);
        push_sample(0, 1'b0);
        push_sample(65535, 1'b0);
        push_sample(gen_tbl[0], 1'b0);
        push_sample(gen_tbl[190], 1'b0);
        push_sample(gen_tbl[190] + 1, 1'b0);
        push_sample(gen_tbl[127], 1'b0);
        push_sample(gen_tbl[128] - 1, 1'b0);
        push_sample(gen_tbl[128], 1'b0);
        // held samples change nothing
        push_sample(gen_tbl[100], 1'b1);
        push_sample(65535, 1'b1);
        // zero at entry 0 makes a zero reading valid
        push_load(0, 0);
        push_sample(0, 1'b0);
        push_load(0, saved);
        push_load(255, 65535);
        push_sample(gen_tbl[255], 1'b0);
        push_sample(gen_tbl[64], 1'b0);
        gen_random(30);

        // Limit of zero, widest range and window
        configure_phase(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 51, 0);
        gen_random(30);

        configure_phase(8'd3, 8'd100, 8'd50, 8'd80, 8'd255, 0, 51);
        gen_random(30);

        // Narrowest range, saturated limit
        configure_phase(8'd255, 8'd0, 8'd0, 8'd0, 8'd128, 9, 9);
        gen_random(30);

        // Empty recovery window
        configure_phase(8'd5, 8'd200, 8'd120, 8'd40, 8'd77, 0, 0);
        gen_random(30);

        configure_phase(8'd2, 8'd150, 8'd0, 8'd149, 8'd200, 51, 0);
        gen_random(30);

        configure_phase(8'd10, 8'd254, 8'd30, 8'd250, 8'd5, 0, 51);
        gen_random(30);

        configure_phase(8'd1, 8'd128, 8'd100, 8'd128, 8'd99, 9, 9);
        gen_random(30);

        drain_all();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
